@@ design/ipv6_text_to_address_macros.svh @@
// Assertion macros shared by the IPv6 text parser modules.
// Depends on nothing; each asserting module includes this file.
`ifndef IPV6_TEXT_TO_ADDRESS_MACROS_SVH
`define IPV6_TEXT_TO_ADDRESS_MACROS_SVH

`ifndef SYNTHESIS
// Plain property check, disabled while reset is held.
`define IPV6T_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition in one cycle leads to a consequence in the next.
`define IPV6T_ASSERT_NEXT(label, clk, rst_n, cause, effect, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
    else $error(msg);
`else
`define IPV6T_ASSERT(label, clk, rst_n, prop, msg)
`define IPV6T_ASSERT_NEXT(label, clk, rst_n, cause, effect, msg)
`endif

`endif

@@ design/ipv6t_pkg.sv @@
// Shared types and constants of the IPv6 text parser.
// Depends on nothing; used by every module of the block.
package ipv6t_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int GROUPS          = 8;
  localparam int GROUP_W         = 16;

  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [3:0] MAX_GROUPS = 4'd8;
  localparam logic [1:0] LEN_FULL   = 2'd2;

  typedef enum logic [2:0] {
    PH_START,
    PH_LEAD,
    PH_BODY,
    PH_SUFFIX,
    PH_FAIL
  } phase_t;

  // One classified character as it travels through the queue.
  typedef struct packed {
    logic [3:0] hex_val;
    logic       is_hex;
    logic       is_colon;
    logic       is_pct;
    logic       last;
  } char_class_t;

  // Parser state captured at the end of a string, ready for expansion.
  typedef struct packed {
    logic [GROUPS-1:0][GROUP_W-1:0] words;
    logic [3:0]                     count;
    logic [3:0]                     gap_index;
    logic                           gap_seen;
    logic                           hex_seen;
    logic [GROUP_W-1:0]             hex_accum;
    logic                           bad;
  } snap_t;

endpackage

@@ design/ipv6t_front.sv @@
// Input side of the IPv6 text parser: accepts characters and classifies them.
// Depends on ipv6t_pkg.
module ipv6t_front (
  input  logic                  in_valid,
  input  logic [7:0]            in_ch,
  input  logic                  in_last,
  output logic                  in_stall,
  input  logic                  q_full,
  output logic                  q_push,
  output ipv6t_pkg::char_class_t q_item
);

  always_comb begin
    q_item          = '0;
    q_item.last     = in_last;
    q_item.is_colon = (in_ch == ipv6t_pkg::CH_COLON);
    q_item.is_pct   = (in_ch == ipv6t_pkg::CH_PERCENT);
    if (in_ch inside {[8'h30:8'h39]}) begin
      q_item.is_hex  = 1'b1;
      q_item.hex_val = in_ch[3:0];
    end else if (in_ch inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      // Letters a-f and A-F share their low nibble: 1 for a, 6 for f.
      q_item.is_hex  = 1'b1;
      q_item.hex_val = in_ch[3:0] + 4'd9;
    end
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

endmodule

@@ design/ipv6t_queue.sv @@
// Short queue of classified characters between the front and the parser.
// Depends on ipv6t_pkg and the assertion macros.
`include "ipv6_text_to_address_macros.svh"
module ipv6t_queue #(
  parameter int DEPTH = ipv6t_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  ipv6t_pkg::char_class_t wdata,
  output logic                   full,
  input  logic                   pop,
  output ipv6t_pkg::char_class_t rdata,
  output logic                   not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ipv6t_pkg::char_class_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_pop;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_pop    = pop && not_empty;
  assign rdata     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  `IPV6T_ASSERT(a_queue_bound, clk, rst_n, cnt_r <= CNT_W'(DEPTH), "queue count beyond depth")
  `IPV6T_ASSERT(a_queue_no_overrun, clk, rst_n, push |-> !full, "push into a full queue")

endmodule

@@ design/ipv6t_parse.sv @@
// Character parser of the IPv6 text block: group, gap and phase tracking.
// Depends on ipv6t_pkg and the assertion macros.
`include "ipv6_text_to_address_macros.svh"
module ipv6t_parse (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   head_valid,
  input  ipv6t_pkg::char_class_t head,
  output logic                   head_pop,
  input  logic                   snap_free,
  output logic                   snap_valid,
  output ipv6t_pkg::snap_t       snap
);

  ipv6t_pkg::phase_t phase_r, phase_nxt;
  logic [ipv6t_pkg::GROUPS-1:0][ipv6t_pkg::GROUP_W-1:0] words_r, words_nxt;
  logic [3:0]                   count_r, count_nxt;
  logic [3:0]                   gap_index_r, gap_index_nxt;
  logic                         gap_seen_r, gap_seen_nxt;
  logic [ipv6t_pkg::GROUP_W-1:0] accum_r, accum_nxt;
  logic                         hex_seen_r, hex_seen_nxt;
  logic                         colon_pend_r, colon_pend_nxt;
  logic [1:0]                   len_r, len_nxt;
  logic                         do_body;
  logic                         consume;
  logic                         snap_valid_r;
  ipv6t_pkg::snap_t             snap_r, snap_nxt;

  // A final character waits until the snapshot register can take it.
  assign head_pop   = head_valid && (!head.last || snap_free);
  assign consume    = head_pop;
  assign snap_valid = snap_valid_r;
  assign snap       = snap_r;

  always_comb begin
    phase_nxt      = phase_r;
    words_nxt      = words_r;
    count_nxt      = count_r;
    gap_index_nxt  = gap_index_r;
    gap_seen_nxt   = gap_seen_r;
    accum_nxt      = accum_r;
    hex_seen_nxt   = hex_seen_r;
    colon_pend_nxt = colon_pend_r;
    do_body        = 1'b0;
    len_nxt        = (len_r == ipv6t_pkg::LEN_FULL) ? len_r : len_r + 2'd1;

    case (phase_r)
      ipv6t_pkg::PH_START: begin
        if (head.is_colon) begin
          phase_nxt = ipv6t_pkg::PH_LEAD;
        end else begin
          phase_nxt = ipv6t_pkg::PH_BODY;
          do_body   = 1'b1;
        end
      end
      ipv6t_pkg::PH_LEAD: begin
        if (!head.is_colon) begin
          phase_nxt = ipv6t_pkg::PH_FAIL;
        end else begin
          phase_nxt = ipv6t_pkg::PH_BODY;
          do_body   = 1'b1;
        end
      end
      ipv6t_pkg::PH_BODY: begin
        do_body = 1'b1;
      end
      ipv6t_pkg::PH_SUFFIX: begin
        phase_nxt = ipv6t_pkg::PH_SUFFIX;
      end
      default: begin
        phase_nxt = ipv6t_pkg::PH_FAIL;
      end
    endcase

    if (do_body) begin
      if (colon_pend_r && head.is_pct) begin
        // A group-ending colon directly before the scope mark.
        phase_nxt = ipv6t_pkg::PH_FAIL;
      end else begin
        colon_pend_nxt = 1'b0;
        if (head.is_hex) begin
          if (accum_r[15:12] != 4'd0) begin
            phase_nxt = ipv6t_pkg::PH_FAIL;
          end else begin
            accum_nxt    = {accum_r[11:0], head.hex_val};
            hex_seen_nxt = 1'b1;
          end
        end else if (head.is_pct) begin
          phase_nxt = head.last ? ipv6t_pkg::PH_FAIL : ipv6t_pkg::PH_SUFFIX;
        end else if (!head.is_colon) begin
          phase_nxt = ipv6t_pkg::PH_FAIL;
        end else if (!hex_seen_r) begin
          if (gap_seen_r) begin
            phase_nxt = ipv6t_pkg::PH_FAIL;
          end else begin
            gap_seen_nxt  = 1'b1;
            gap_index_nxt = count_r;
          end
        end else if (count_r >= ipv6t_pkg::MAX_GROUPS) begin
          phase_nxt = ipv6t_pkg::PH_FAIL;
        end else begin
          words_nxt[count_r[2:0]] = accum_r;
          count_nxt               = count_r + 4'd1;
          accum_nxt               = '0;
          hex_seen_nxt            = 1'b0;
          colon_pend_nxt          = 1'b1;
        end
      end
    end

    snap_nxt.words     = words_nxt;
    snap_nxt.count     = count_nxt;
    snap_nxt.gap_index = gap_index_nxt;
    snap_nxt.gap_seen  = gap_seen_nxt;
    snap_nxt.hex_seen  = hex_seen_nxt;
    snap_nxt.hex_accum = accum_nxt;
    snap_nxt.bad       = (phase_nxt == ipv6t_pkg::PH_FAIL) || colon_pend_nxt ||
                         (len_nxt != ipv6t_pkg::LEN_FULL);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= ipv6t_pkg::PH_START;
      count_r      <= '0;
      gap_index_r  <= '0;
      gap_seen_r   <= 1'b0;
      accum_r      <= '0;
      hex_seen_r   <= 1'b0;
      colon_pend_r <= 1'b0;
      len_r        <= '0;
      snap_valid_r <= 1'b0;
    end else begin
      if (consume && head.last) begin
        snap_valid_r <= 1'b1;
      end else if (snap_free) begin
        snap_valid_r <= 1'b0;
      end
      if (consume) begin
        if (head.last) begin
          phase_r      <= ipv6t_pkg::PH_START;
          count_r      <= '0;
          gap_index_r  <= '0;
          gap_seen_r   <= 1'b0;
          accum_r      <= '0;
          hex_seen_r   <= 1'b0;
          colon_pend_r <= 1'b0;
          len_r        <= '0;
        end else begin
          phase_r      <= phase_nxt;
          count_r      <= count_nxt;
          gap_index_r  <= gap_index_nxt;
          gap_seen_r   <= gap_seen_nxt;
          accum_r      <= accum_nxt;
          hex_seen_r   <= hex_seen_nxt;
          colon_pend_r <= colon_pend_nxt;
          len_r        <= len_nxt;
        end
      end
    end
  end

  // Group words are only read where they were written in the same string.
  always_ff @(posedge clk) begin
    if (consume && !head.last) begin
      words_r <= words_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && head.last) begin
      snap_r <= snap_nxt;
    end
  end

  `IPV6T_ASSERT_NEXT(a_snap_hold, clk, rst_n, snap_valid_r && !snap_free,
    snap_valid_r && $stable(snap_r), "snapshot lost while held")
  `IPV6T_ASSERT_NEXT(a_string_clear, clk, rst_n, consume && head.last,
    phase_r == ipv6t_pkg::PH_START && count_r == '0 && !gap_seen_r, "state not cleared")

endmodule

@@ design/ipv6t_expand.sv @@
// Final check and gap expansion of the IPv6 text parser, with output register.
// Depends on ipv6t_pkg and the assertion macros.
`include "ipv6_text_to_address_macros.svh"
module ipv6t_expand (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             snap_valid,
  input  ipv6t_pkg::snap_t snap,
  output logic             snap_free,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [63:0]      out_addr_high,
  output logic [63:0]      out_addr_low,
  output logic             out_ok
);

  logic                         out_valid_r;
  logic [63:0]                  addr_high_r, addr_high_nxt;
  logic [63:0]                  addr_low_r, addr_low_nxt;
  logic                         ok_r, ok_nxt;
  logic                         out_free;
  logic [ipv6t_pkg::GROUPS-1:0][ipv6t_pkg::GROUP_W-1:0] words2;
  logic [ipv6t_pkg::GROUPS-1:0][ipv6t_pkg::GROUP_W-1:0] full;
  logic [3:0]                   count2;
  logic [3:0]                   tail;
  logic [3:0]                   start;
  logic                         fail;

  assign out_free  = !out_valid_r || !out_stall;
  assign snap_free = out_free;

  always_comb begin
    words2 = snap.words;
    count2 = snap.count;
    full   = '0;
    // A group still open at the end of the text is closed here.
    if (snap.hex_seen && (snap.count < ipv6t_pkg::MAX_GROUPS)) begin
      words2[snap.count[2:0]] = snap.hex_accum;
    end
    if (snap.hex_seen) begin
      count2 = snap.count + 4'd1;
    end
    fail = snap.bad || (snap.hex_seen && (snap.count >= ipv6t_pkg::MAX_GROUPS)) ||
           (snap.gap_seen ? (count2 >= ipv6t_pkg::MAX_GROUPS)
                          : (count2 != ipv6t_pkg::MAX_GROUPS));
    tail  = count2 - snap.gap_index;
    start = ipv6t_pkg::MAX_GROUPS - tail;
    for (int k = 0; k < ipv6t_pkg::GROUPS; k++) begin
      if (!snap.gap_seen || (4'(k) < snap.gap_index)) begin
        full[k] = words2[k];
      end else if (4'(k) >= start) begin
        // Groups after the gap slide to the end of the address.
        full[k] = words2[3'(k) + count2[2:0]];
      end else begin
        full[k] = '0;
      end
    end
    ok_nxt        = !fail;
    addr_high_nxt = fail ? 64'd0 : {full[0], full[1], full[2], full[3]};
    addr_low_nxt  = fail ? 64'd0 : {full[4], full[5], full[6], full[7]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && snap_valid) begin
      addr_high_r <= addr_high_nxt;
      addr_low_r  <= addr_low_nxt;
      ok_r        <= ok_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_addr_high = addr_high_r;
  assign out_addr_low  = addr_low_r;
  assign out_ok        = ok_r;

  `IPV6T_ASSERT(a_fail_zero, clk, rst_n,
    out_valid_r && !ok_r |-> addr_high_r == 64'd0 && addr_low_r == 64'd0,
    "failed result carries a nonzero address")

endmodule

@@ design/ipv6_text_to_address.sv @@
// Top level of the IPv6 text-to-address parser.
// Depends on ipv6t_pkg, ipv6t_front, ipv6t_queue, ipv6t_parse and ipv6t_expand.
//
//   Channel | Direction | Handshake          | Payload
//   in_     | input     | in_valid/in_stall  | in_ch[7:0], in_last
//   out_    | output    | out_valid/out_stall| out_addr_high[63:0], out_addr_low[63:0], out_ok
//
// One character item is taken every cycle while the queue has room; the parser
// sustains one item per cycle but for a final character whose snapshot cannot move on.
// After its final character is accepted, a result passes through the queue, the
// parser snapshot, then expansion into the output register.
// Reset is synchronous and clears only control state; no clearing pass is needed.
// out_stall holds the output register; the parser waits only on a final character
// whose snapshot cannot move on, and in_stall rises once the queue fills.
module ipv6_text_to_address #(
  parameter int QUEUE_DEPTH = ipv6t_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_ch,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_addr_high,
  output logic [63:0] out_addr_low,
  output logic        out_ok
);

  // Classified characters flowing from the front into the queue.
  ipv6t_pkg::char_class_t q_item;
  ipv6t_pkg::char_class_t q_head;
  logic                   q_push;
  logic                   q_full;
  logic                   q_pop;
  logic                   q_not_empty;

  // End-of-string snapshot handed from the parser to the expansion stage.
  ipv6t_pkg::snap_t       snap;
  logic                   snap_valid;
  logic                   snap_free;

  // The front decodes each character into hex, colon and percent flags.
  ipv6t_front u_front (
    .in_valid (in_valid),
    .in_ch    (in_ch),
    .in_last  (in_last),
    .in_stall (in_stall),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_item)
  );

  // The queue lets input and parser stall independently of each other.
  ipv6t_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .rdata     (q_head),
    .not_empty (q_not_empty)
  );

  // The parser steps through the text and captures its state at the last item.
  ipv6t_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_not_empty),
    .head       (q_head),
    .head_pop   (q_pop),
    .snap_free  (snap_free),
    .snap_valid (snap_valid),
    .snap       (snap)
  );

  // Expansion fills the gap with zero groups and registers the result.
  ipv6t_expand u_expand (
    .clk           (clk),
    .rst_n         (rst_n),
    .snap_valid    (snap_valid),
    .snap          (snap),
    .snap_free     (snap_free),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_addr_high (out_addr_high),
    .out_addr_low  (out_addr_low),
    .out_ok        (out_ok)
  );

endmodule
